FILE: src/first_fit_heap_allocator_assert.svh
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define FFHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define FFHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: src/ffha_pkg.sv
package ffha_pkg;
    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_ZERO = 3'd1;
    localparam logic [2:0] ST_OOM  = 3'd2;
    localparam logic [2:0] ST_BAD  = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;
    localparam logic       CMD_ALLOC = 1'b0;
    localparam logic       CMD_FREE  = 1'b1;
    localparam logic [0:0] REG_BASE  = 1'b0;
    localparam logic [0:0] REG_BYTES = 1'b1;
endpackage

FILE: src/ffha_seg_ram.sv
// Segment table: one write port, one registered read port.
module ffha_seg_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 80
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

FILE: src/first_fit_heap_allocator.sv
// Channel | valid   | stall   | payload
// request | i_valid | o_stall | i_cmd, i_req_size, i_free_addr
// result  | o_valid | i_stall | o_grant_addr, o_status
// Config  | i_cfg_we, i_cfg_index, i_cfg_data
// One request at a time; each list step reads an entry, then uses it. An alloc walks the
// list; a split scans for the lowest spare entry, writes it, fixes the next back link and
// rewrites the current entry. A matching free merges with free neighbours, then writes back.
// Zero size, null pointer or an unusable heap answer without a list walk.
// Reset clears the table; after a config write entry 0 is rebuilt while the block stalls.
// A result waits in the output register; the block is stalled until it is taken.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int HEADER_BYTES = 20,
    parameter int ALIGN_BYTES  = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [31:0] i_req_size,
    input  logic [31:0] i_free_addr,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_grant_addr,
    output logic [2:0]  o_status,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    `include "first_fit_heap_allocator_assert.svh"

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int LW = AW + 1;
    localparam logic [LW-1:0] NIL = '1;
    localparam int DW = 64 + 2 * LW;
    localparam logic [33:0] HDR = 34'(HEADER_BYTES);
    localparam logic [33:0] ALN = 34'(ALIGN_BYTES);

    typedef struct packed {
        logic [31:0]   start;
        logic [31:0]   size;
        logic [LW-1:0] nxt;
        logic [LW-1:0] prv;
    } t_seg;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_CHK, S_SCAN, S_SPLIT_RDN, S_SPLIT_N, S_SPLIT_W,
        S_F_RDN, S_F_N, S_F_RDA, S_F_A, S_F_RDP, S_F_P, S_F_RDA2, S_F_A2,
        S_F_WC, S_OUT
    } t_state;

    t_state r_state;
    logic [MAX_SEGMENTS-1:0] r_live, r_free;
    logic [LW-1:0] r_head, r_cur, r_spare, r_nx;
    logic [31:0] r_base, r_bytes;
    logic        r_cmd;
    logic [33:0] r_need;
    logic [31:0] r_addr;
    logic [AW:0] r_steps;
    t_seg        r_c, r_n;
    logic [31:0] r_grant;
    logic [2:0]  r_status;
    logic        r_ovalid;

    logic          n_we;
    logic [AW-1:0] n_waddr, n_raddr;
    t_seg          n_wdata, w_rd;
    logic [DW-1:0] w_rbits;
    logic          w_rebuild;

    ffha_seg_ram #(.DEPTH(MAX_SEGMENTS), .AW(AW), .DW(DW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (n_we),
        .i_waddr(n_waddr),
        .i_wdata(n_wdata),
        .i_raddr(n_raddr),
        .o_rdata(w_rbits)
    );
    assign w_rd = t_seg'(w_rbits);

    function automatic logic ok(input logic [LW-1:0] i, input logic [MAX_SEGMENTS-1:0] lv);
        return (i < LW'(MAX_SEGMENTS)) && lv[i[AW-1:0]];
    endfunction

    logic [31:0] w_pay;
    assign w_pay = r_base + w_rd.start + 32'(HEADER_BYTES);

    // table cleared by a config write, heap big enough, but entry 0 not yet written
    assign w_rebuild = (r_head == NIL) && (r_live == '0) && !r_free[0]
                       && ({2'b0, r_bytes} >= HDR + ALN);

    always_comb begin
        n_we = 1'b0;
        n_waddr = r_cur[AW-1:0];
        n_wdata = r_c;
        n_raddr = r_cur[AW-1:0];
        case (r_state)
            S_SPLIT_RDN: n_raddr = r_nx[AW-1:0];
            S_F_RDN:     n_raddr = r_nx[AW-1:0];
            S_F_RDA, S_F_RDA2: n_raddr = r_nx[AW-1:0];
            S_F_RDP:     n_raddr = r_c.prv[AW-1:0];
            S_SPLIT_N: begin
                n_we = 1'b1;
                n_waddr = r_spare[AW-1:0];
                n_wdata.start = r_c.start + 32'(HEADER_BYTES) + r_need[31:0];
                n_wdata.size  = r_c.size - r_need[31:0] - 32'(HEADER_BYTES);
                n_wdata.nxt   = r_c.nxt;
                n_wdata.prv   = r_cur;
            end
            S_SPLIT_W: begin
                n_we = 1'b1;
                n_wdata.size = r_need[31:0];
                n_wdata.nxt  = r_spare;
            end
            S_F_A: begin
                n_we = ok(r_nx, r_live);
                n_waddr = r_nx[AW-1:0];
                n_wdata = w_rd;
                n_wdata.prv = r_cur;
            end
            S_F_A2: begin
                n_we = ok(r_nx, r_live);
                n_waddr = r_nx[AW-1:0];
                n_wdata = w_rd;
                n_wdata.prv = r_spare;
            end
            S_F_WC: begin
                n_we = 1'b1;
                n_waddr = r_spare[AW-1:0];
                n_wdata = (r_spare == r_cur) ? r_c : r_n;
            end
            default: ;
        endcase
        if (r_state == S_IDLE && !r_ovalid && !i_cfg_we) n_we = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_live   <= '0;
            r_free   <= '0;
            r_head   <= NIL;
            if (!i_rst_n) begin
                r_base  <= '0;
                r_bytes <= '0;
            end else begin
                if (i_cfg_index == REG_BASE) r_base <= i_cfg_data;
                else r_bytes <= i_cfg_data;
            end
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    // Heap rebuild is done in idle: entry 0 is written before the next request is taken.
                    if (w_rebuild) begin
                        r_c     <= '{start: '0, size: r_bytes - 32'(HEADER_BYTES),
                                     nxt: NIL, prv: NIL};
                        r_cur   <= '0;
                        r_spare <= '0;
                        r_head  <= '0;
                        r_live[0] <= 1'b1;
                        r_free[0] <= 1'b1;
                        r_state <= S_F_WC;
                        r_cmd   <= CMD_ALLOC;
                    end else if (i_valid && !r_ovalid) begin
                        r_cmd    <= i_cmd;
                        r_need   <= (({2'b0, i_req_size} + ALN - 34'd1) / ALN) * ALN;
                        r_addr   <= i_free_addr;
                        r_cur    <= r_head;
                        r_steps  <= '0;
                        r_grant  <= '0;
                        if (i_cmd == CMD_ALLOC && i_req_size == '0) begin
                            r_status <= ST_ZERO;
                            r_state  <= S_OUT;
                        end else if (i_cmd == CMD_FREE && i_free_addr == '0) begin
                            r_status <= ST_ZERO;
                            r_state  <= S_OUT;
                        end else begin
                            r_status <= (i_cmd == CMD_ALLOC) ? ST_OOM : ST_BAD;
                            r_state  <= ok(r_head, r_live) ? S_RD : S_OUT;
                        end
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    r_c <= w_rd;
                    r_steps <= r_steps + 1'b1;
                    if (r_cmd == CMD_ALLOC) begin
                        if (r_free[r_cur[AW-1:0]] && {2'b0, w_rd.size} >= r_need) begin
                            if ({2'b0, w_rd.size} >= r_need + HDR + ALN) begin
                                r_spare <= '0;
                                r_state <= S_SCAN;
                            end else begin
                                r_free[r_cur[AW-1:0]] <= 1'b0;
                                r_grant  <= w_pay;
                                r_status <= ST_OK;
                                r_state  <= S_OUT;
                            end
                        end else if (ok(w_rd.nxt, r_live)
                                     && r_steps + 1'b1 < (AW+1)'(MAX_SEGMENTS)) begin
                            r_cur <= w_rd.nxt;
                            r_state <= S_RD;
                        end else r_state <= S_OUT;
                    end else begin
                        if (w_pay == r_addr) begin
                            if (r_free[r_cur[AW-1:0]]) r_state <= S_OUT;
                            else begin
                                r_free[r_cur[AW-1:0]] <= 1'b1;
                                r_status <= ST_OK;
                                r_nx <= w_rd.nxt;
                                r_state <= S_F_RDN;
                            end
                        end else if (ok(w_rd.nxt, r_live)
                                     && r_steps + 1'b1 < (AW+1)'(MAX_SEGMENTS)) begin
                            r_cur <= w_rd.nxt;
                            r_state <= S_RD;
                        end else r_state <= S_OUT;
                    end
                end
                S_SCAN: begin
                    if (!r_live[r_spare[AW-1:0]]) begin
                        r_nx <= r_c.nxt;
                        r_state <= S_SPLIT_N;
                    end else if (r_spare == LW'(MAX_SEGMENTS - 1)) begin
                        r_status <= ST_FULL;
                        r_state <= S_OUT;
                    end else r_spare <= r_spare + 1'b1;
                end
                S_SPLIT_N: begin
                    r_live[r_spare[AW-1:0]] <= 1'b1;
                    r_free[r_spare[AW-1:0]] <= 1'b1;
                    r_state <= S_SPLIT_RDN;
                end
                S_SPLIT_RDN: r_state <= S_F_RDA2;
                S_F_RDA2: r_state <= S_F_A2;
                // split goes on to rewrite the current entry; a free writes the merged prev
                S_F_A2: r_state <= (r_cmd == CMD_FREE) ? S_F_WC : S_SPLIT_W;
                S_SPLIT_W: begin
                    r_free[r_cur[AW-1:0]] <= 1'b0;
                    r_grant  <= r_base + r_c.start + 32'(HEADER_BYTES);
                    r_status <= ST_OK;
                    r_state  <= S_OUT;
                end
                S_F_RDN: r_state <= S_F_N;
                S_F_N: begin
                    if (ok(r_nx, r_live) && r_free[r_nx[AW-1:0]]) begin
                        r_c <= '{start: r_c.start,
                                 size: r_c.size + 32'(HEADER_BYTES) + w_rd.size,
                                 nxt: w_rd.nxt, prv: r_c.prv};
                        r_live[r_nx[AW-1:0]] <= 1'b0;
                        r_free[r_nx[AW-1:0]] <= 1'b0;
                        r_nx <= w_rd.nxt;
                        r_state <= S_F_RDA;
                    end else r_state <= S_F_RDP;
                end
                S_F_RDA: r_state <= S_F_A;
                S_F_A: r_state <= S_F_RDP;
                S_F_RDP: r_state <= S_F_P;
                S_F_P: begin
                    if (ok(r_c.prv, r_live) && r_free[r_c.prv[AW-1:0]]) begin
                        r_n <= '{start: w_rd.start,
                                 size: w_rd.size + 32'(HEADER_BYTES) + r_c.size,
                                 nxt: r_c.nxt, prv: w_rd.prv};
                        r_spare  <= r_c.prv;
                        r_live[r_cur[AW-1:0]] <= 1'b0;
                        r_free[r_cur[AW-1:0]] <= 1'b0;
                        r_nx <= r_c.nxt;
                        r_state <= S_F_RDA2;
                    end else begin
                        r_spare <= r_cur;
                        r_state <= S_F_WC;
                    end
                end
                S_F_WC: r_state <= (r_cmd == CMD_FREE && r_status == ST_OK) ? S_OUT : S_IDLE;
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    o_grant_addr <= r_grant;
                    o_status <= r_status;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_stall = r_ovalid || (r_state != S_IDLE) || i_cfg_we || w_rebuild;

    `FFHA_ASSERT_IMP(a_head_live, i_clk, i_rst_n,
        (r_head != NIL && r_state == S_IDLE && !r_ovalid && r_live != '0),
        r_live[r_head[AW-1:0]])
    `FFHA_ASSERT_IMP(a_free_live, i_clk, i_rst_n, 1'b1, ((r_free & ~r_live) == '0))
    `FFHA_ASSERT_NXT(a_out_ok, i_clk, i_rst_n,
        (r_state == S_OUT), (o_valid && o_status <= ST_FULL))
endmodule
